FILE: hw/rtl/xbd_pkg.sv
`default_nettype none

package xbd_pkg;

  localparam int WIN_LEN = 5;

  localparam logic [7:0]  OPC_MASK = 8'hFE;
  localparam logic [7:0]  OPC_CALL = 8'hE8;
  localparam logic [31:0] IP_ADV   = 32'd5;
  localparam logic [31:0] POS_ONE  = 32'd1;

  localparam logic [2:0] FILL_FULL = 3'd4;
  localparam logic [2:0] CNT_NONE  = 3'd0;
  localparam logic [2:0] CNT_ONE   = 3'd1;
  localparam logic [2:0] CNT_GROUP = 3'd5;
  localparam logic [1:0] SKIP_SAT  = 2'd3;

  typedef logic [7:0] byte_t;

  // work of one accepted byte, before the address fix
  typedef struct packed {
    logic [2:0]                cnt;
    logic                      conv;
    logic                      last;
    logic [2:0]                m;
    logic [31:0]               diff;
    logic [31:0]               cur;
    logic [WIN_LEN-1:0][7:0]   win;
  } group_t;

  // finished bytes of one accepted byte
  typedef struct packed {
    logic [2:0]                cnt;
    logic                      last;
    logic [WIN_LEN-1:0][7:0]   bytes;
  } rgroup_t;

  function automatic logic is_ms_byte(input byte_t v);
    return (v == 8'h00) || (v == 8'hFF);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/xbd_ifs.sv
`default_nettype none

interface xbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, in_byte, stream_end, input ready);
  modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface xbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;
  modport source (output valid, out_byte, run_last, stream_last, input ready);
  modport sink   (input valid, out_byte, run_last, stream_last, output ready);
endinterface

interface xbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_ip;
  modport source (output valid, start_ip, input ready);
  modport sink   (input valid, start_ip, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/x86_call_jump_branch_decoder.sv
// output path: the input transfer that completes a group registers it in the window stage;
//   the group then enters the output queue, from which its first byte is offered
// throughput: one input byte per cycle while the queue has room, one output byte per cycle
//   while ready is high; a converted five-byte group drains via a QUEUE_DEPTH-group queue
// reset (rst, synchronous): window empty, mask, skip count and position cleared, start_ip 0
`default_nettype none

module x86_call_jump_branch_decoder import xbd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  xbd_in_if.sink    stream,
  xbd_cfg_if.sink   cfg,
  xbd_out_if.source result
);

  // stage one: window, candidate tests and the raw ip subtraction
  group_t  grp;
  logic    grp_valid;
  // stage two: masked-candidate fix, straight into the group queue
  rgroup_t rgrp;
  // queue has space for the group in flight plus a new one
  logic    room;

  xbd_window u_window (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .cfg       (cfg),
    .room      (room),
    .grp       (grp),
    .grp_valid (grp_valid)
  );

  // for a converted group, turns the target back to relative and sign-fills the top byte
  xbd_fix u_fix (
    .grp  (grp),
    .rgrp (rgrp)
  );

  // holds finished groups and hands them out one byte per transfer
  xbd_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .rgrp   (rgrp),
    .push   (grp_valid),
    .room   (room),
    .result (result)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/xbd_window.sv
`default_nettype none

module xbd_window import xbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  xbd_in_if.sink     stream,
  xbd_cfg_if.sink    cfg,
  input  logic       room,
  output group_t     grp,
  output logic       grp_valid
);

  logic [WIN_LEN-1:0][7:0] win;
  logic [WIN_LEN-1:0][7:0] win_in;
  logic [WIN_LEN-1:0][7:0] win_shift;
  logic [2:0]  fill;
  logic [2:0]  mask;
  logic [1:0]  skip;
  logic [31:0] pos;
  logic [31:0] cur;
  logic [31:0] sip;

  logic        accept;
  logic        full;
  logic        head_opc;
  logic [2:0]  m;
  logic [1:0]  pick_idx;
  logic        rej_prior;
  logic        conv;
  logic [31:0] diff;
  logic [2:0]  cnt;

  assign stream.ready = room;
  assign cfg.ready    = 1'b1;
  assign accept       = stream.valid & stream.ready;

  always_comb begin
    win_in       = win;
    win_in[fill] = stream.in_byte;
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_shift[i] = win_in[i + 1];
    end
    win_shift[WIN_LEN-1] = win_in[WIN_LEN-1];

    full     = (fill == FILL_FULL);
    head_opc = ((win_in[0] & OPC_MASK) == OPC_CALL);

    if (skip == SKIP_SAT) begin
      m = 3'd0;
    end else begin
      m = mask >> skip;
    end
    pick_idx  = m[2:1] + 2'd1;
    rej_prior = (skip != SKIP_SAT) && (m != 3'd0) &&
                ((m > 3'd4) || (m == 3'd3) || is_ms_byte(win_in[{1'b0, pick_idx}]));
    conv      = full && head_opc && !rej_prior && is_ms_byte(win_in[4]);
    diff      = {win_in[4], win_in[3], win_in[2], win_in[1]} - cur;

    if (stream.stream_end) begin
      cnt = (conv || full) ? CNT_GROUP : fill + 3'd1;
    end else if (full) begin
      cnt = conv ? CNT_GROUP : CNT_ONE;
    end else begin
      cnt = CNT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      mask      <= '0;
      skip      <= '0;
      pos       <= '0;
      cur       <= IP_ADV;
      sip       <= '0;
      grp_valid <= 1'b0;
    end else begin
      grp_valid <= accept && (cnt != CNT_NONE);
      if (cfg.valid) begin
        sip <= cfg.start_ip;
        cur <= cfg.start_ip + IP_ADV + pos;
      end
      if (accept) begin
        if (stream.stream_end) begin
          fill <= '0;
          mask <= '0;
          skip <= '0;
          pos  <= '0;
          cur  <= sip + IP_ADV;
        end else if (!full) begin
          fill <= fill + 3'd1;
        end else if (conv) begin
          fill <= '0;
          mask <= '0;
          skip <= '0;
          pos  <= pos + IP_ADV;
          cur  <= cur + IP_ADV;
        end else begin
          fill <= FILL_FULL;
          pos  <= pos + POS_ONE;
          cur  <= cur + POS_ONE;
          if (!head_opc) begin
            if (skip != SKIP_SAT) begin
              skip <= skip + 2'd1;
            end
          end else begin
            mask <= {1'b1, m[2:1]};
            skip <= '0;
          end
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      win       <= full ? win_shift : win_in;
      grp.cnt   <= cnt;
      grp.conv  <= conv;
      grp.last  <= stream.stream_end;
      grp.m     <= m;
      grp.diff  <= diff;
      grp.cur   <= cur;
      grp.win   <= win_in;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && stream.stream_end |=> (fill == 3'd0) && (skip == 2'd0) && (mask == 3'd0))
    else $error("window state not cleared after stream end");

  a_conv_group: assert property (@(posedge clk) disable iff (rst)
    grp_valid && grp.conv |-> grp.cnt == CNT_GROUP)
    else $error("converted group without five bytes");

endmodule

`default_nettype wire

FILE: hw/rtl/xbd_fix.sv
`default_nettype none

module xbd_fix import xbd_pkg::*; (
  input  group_t  grp,
  output rgroup_t rgrp
);

  byte_t       sel;
  logic [31:0] fix_mask;
  logic [31:0] v;

  always_comb begin
    if (grp.m[2]) begin
      sel      = grp.diff[23:16];
      fix_mask = 32'h00FF_FFFF;
    end else if (grp.m[1]) begin
      sel      = grp.diff[15:8];
      fix_mask = 32'h0000_FFFF;
    end else begin
      sel      = grp.diff[7:0];
      fix_mask = 32'h0000_00FF;
    end

    // masked candidate: flip the low bytes and take the ip off once more
    if ((grp.m != 3'd0) && is_ms_byte(sel)) begin
      v = (grp.diff ^ fix_mask) - grp.cur;
    end else begin
      v = grp.diff;
    end

    rgrp.cnt  = grp.cnt;
    rgrp.last = grp.last;
    if (grp.conv) begin
      rgrp.bytes = {{8{v[24]}}, v[23:16], v[15:8], v[7:0], grp.win[0]};
    end else begin
      rgrp.bytes = grp.win;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/xbd_out_queue.sv
`default_nettype none

module xbd_out_queue import xbd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  rgroup_t  rgrp,
  input  logic     push,
  output logic     room,
  xbd_out_if.source result
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rgroup_t       q [DEPTH];
  logic [PW-1:0] wr;
  logic [PW-1:0] rd;
  logic [CW-1:0] count;
  logic [2:0]    idx;
  logic          group_done;
  logic          pop;

  assign room = ({1'b0, count} + (CW + 1)'(push)) < (CW + 1)'(DEPTH);

  assign result.valid       = (count != '0);
  assign result.out_byte    = q[rd].bytes[idx];
  assign result.run_last    = (idx == q[rd].cnt - 3'd1);
  assign result.stream_last = result.run_last && q[rd].last;

  assign group_done = result.valid && result.ready && result.run_last;
  assign pop        = group_done;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr] <= rgrp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (push) begin
        wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
      if (result.valid && result.ready) begin
        idx <= group_done ? 3'd0 : idx + 3'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CW'(DEPTH)) || pop)
    else $error("group queue overflow");

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> idx < q[rd].cnt)
    else $error("byte index beyond group");

endmodule

`default_nettype wire

FILE: dv/tb_x86_call_jump_branch_decoder.sv
`timescale 1ns / 1ps

module tb_x86_call_jump_branch_decoder import xbd_pkg::*;;

  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on any channel
  localparam int SETTLE_CYCLES = 8;     // margin after draining, for the pipeline to settle
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 16;
  localparam int DIR_N         = 23;

  // one raw stream byte as sent, plus an optional hand-written result
  typedef struct packed {
    byte_t data;
    logic  last;
    logic  typed;
    byte_t typed_byte;
  } feed_t;

  // one decoded byte as it should leave the block
  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  stream_last;
  } dec_byte_t;

  // directed streams; typed rows are single-byte streams that must come back as they are
  localparam feed_t DIR_ROWS [DIR_N] = '{
    // short stream of one byte, lowest and highest value
    '{8'h00, 1'b1, 1'b1, 8'h00},
    '{8'hFF, 1'b1, 1'b1, 8'hFF},
    // call with zero target at position 0: converted to -(start_ip + 5)
    '{8'hE8, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00},
    // jump with all-ones top byte, then a four-byte tail that is never examined
    '{8'hE9, 1'b0, 1'b0, 8'h00},
    '{8'h78, 1'b0, 1'b0, 8'h00},
    '{8'h56, 1'b0, 1'b0, 8'h00},
    '{8'h34, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'h90, 1'b0, 1'b0, 8'h00},
    '{8'h90, 1'b0, 1'b0, 8'h00},
    '{8'h90, 1'b0, 1'b0, 8'h00},
    '{8'h90, 1'b1, 1'b0, 8'h00},
    // rejected call sets the mask, the next call converts with that mask set
    '{8'hE8, 1'b0, 1'b0, 8'h00},
    '{8'hE8, 1'b0, 1'b0, 8'h00},
    '{8'h11, 1'b0, 1'b0, 8'h00},
    '{8'h22, 1'b0, 1'b0, 8'h00},
    '{8'h33, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h90, 1'b1, 1'b0, 8'h00}
  };

  logic clk = 1'b0;
  logic rst;

  xbd_in_if  byte_ch ();
  xbd_out_if res_ch ();
  xbd_cfg_if ip_ch ();

  x86_call_jump_branch_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .cfg    (ip_ch),
    .result (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bytes waiting to be sent, decoded bytes waiting to arrive
  feed_t     raw_q [$];
  dec_byte_t decoded_q [$];

  int          mismatch_cnt  = 0;
  int          stall_cycles  = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        cfg_req       = 1'b0;
  logic [31:0] cfg_value     = '0;

  // shadow of the decoder state
  byte_t       win_q [WIN_LEN];
  int          win_fill = 0;
  logic [2:0]  prior_m  = '0;
  logic [1:0]  skip_n   = '0;
  logic [31:0] head_pos = '0;
  logic [31:0] ip_base  = '0;

  // 00 and FF are the only legal top bytes of a near target
  function automatic logic is_fill(input byte_t v);
    return (v == 8'h00) || (v == 8'hFF);
  endfunction

  // random byte, with a share of 00/FF
  function automatic byte_t raw_byte(input int fill_pct);
    if ($urandom_range(99) < fill_pct)
      return $urandom_range(1) ? 8'hFF : 8'h00;
    return byte_t'($urandom);
  endfunction

  // work out the decoded bytes caused by one accepted stream byte
  task automatic decode_transfer(input feed_t f);
    byte_t       outs [WIN_LEN];
    int          n;
    int          sh;
    logic [2:0]  m;
    logic        reject;
    logic        convert;
    logic [31:0] v;
    logic [31:0] cur;
    n       = 0;
    m       = '0;
    reject  = 1'b0;
    convert = 1'b0;
    win_q[win_fill] = f.data;
    win_fill++;
    if (win_fill == WIN_LEN) begin
      if ((win_q[0] & OPC_MASK) != OPC_CALL) begin
        // not an opcode: count it toward the skip distance
        if (skip_n != SKIP_SAT)
          skip_n++;
      end else begin
        m = prior_m;
        if (skip_n == SKIP_SAT) begin
          m = '0;
        end else begin
          m = m >> skip_n;
          if (m != 0 && (m > 3'd4 || m == 3'd3 || is_fill(win_q[((int'(m) >> 1) + 1) & 3])))
            reject = 1'b1;
        end
        if (!reject && !is_fill(win_q[4]))
          reject = 1'b1;
        if (reject) begin
          prior_m = (m >> 1) | 3'd4;
          skip_n  = '0;
        end else begin
          convert = 1'b1;
        end
      end
      if (convert) begin
        // absolute target back to relative, with the masked-candidate fix
        v   = {win_q[4], win_q[3], win_q[2], win_q[1]};
        cur = ip_base + 32'd5 + head_pos;
        v   = v - cur;
        if (m != 0) begin
          sh = (int'(m) & 6) << 2;
          if (is_fill(v[sh +: 8])) begin
            v = v ^ ((32'h100 << sh) - 32'd1);
            v = v - cur;
          end
        end
        prior_m = '0;
        skip_n  = '0;
        outs[0] = win_q[0];
        outs[1] = v[7:0];
        outs[2] = v[15:8];
        outs[3] = v[23:16];
        outs[4] = {8{v[24]}};
        n        = 5;
        win_fill = 0;
        head_pos = head_pos + 32'd5;
      end else begin
        // head leaves unchanged, window slides by one
        outs[0] = win_q[0];
        n       = 1;
        for (int i = 1; i < WIN_LEN; i++)
          win_q[i - 1] = win_q[i];
        win_fill = WIN_LEN - 1;
        head_pos = head_pos + 32'd1;
      end
    end
    if (f.last) begin
      // stream end: flush what is left and clear state, start_ip stays
      for (int i = 0; i < win_fill; i++) begin
        outs[n] = win_q[i];
        n++;
      end
      win_fill = 0;
      prior_m  = '0;
      skip_n   = '0;
      head_pos = '0;
    end
    if (f.typed) begin
      decoded_q.push_back(dec_byte_t'{f.typed_byte, 1'b1, 1'b1});
    end else begin
      for (int i = 0; i < n; i++)
        decoded_q.push_back(dec_byte_t'{outs[i], i == n - 1, (i == n - 1) && f.last});
    end
  endtask

  // build one stream of calls, jumps and filler; short streams now and then
  task automatic queue_stream(output int count);
    byte_t body [$];
    int    len;
    len = ($urandom_range(9) == 0) ? $urandom_range(4, 1) : $urandom_range(40, 6);
    while (body.size() < len) begin
      if ($urandom_range(99) < 45) begin
        body.push_back(OPC_CALL | byte_t'($urandom_range(1)));
        repeat (3) body.push_back(raw_byte(20));
        // mostly a well-formed top byte, sometimes a broken one
        body.push_back(raw_byte(85));
      end else if ($urandom_range(99) < 10) begin
        body.push_back(OPC_CALL | byte_t'($urandom_range(1)));
      end else begin
        body.push_back(raw_byte(15));
      end
    end
    for (int i = 0; i < body.size(); i++)
      raw_q.push_back(feed_t'{body[i], i == body.size() - 1, 1'b0, 8'h00});
    count = body.size();
  endtask

  // all channel traffic, prediction and checking at the rising edge
  always @(posedge clk) begin : channel_drive
    dec_byte_t want;
    logic      moved;
    moved = (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (ip_ch.valid && ip_ch.ready);
    if (rst) begin
      byte_ch.valid <= 1'b0;
      res_ch.ready  <= 1'b0;
      ip_ch.valid   <= 1'b0;
      stall_cycles  <= 0;
    end else begin
      // input side: predict on transfer, then offer the next byte or idle
      if (byte_ch.valid && byte_ch.ready)
        decode_transfer(raw_q.pop_front());
      if (!byte_ch.valid || byte_ch.ready) begin
        if (raw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_ch.valid      <= 1'b1;
          byte_ch.in_byte    <= raw_q[0].data;
          byte_ch.stream_end <= raw_q[0].last;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end

      // output side: compare with the oldest expected byte
      if (res_ch.valid && res_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h", res_ch.out_byte);
          mismatch_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (res_ch.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, res_ch.out_byte);
            mismatch_cnt++;
          end
          if (res_ch.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, res_ch.run_last);
            mismatch_cnt++;
          end
          if (res_ch.stream_last !== want.stream_last) begin
            $error("stream_last: expected %b, got %b", want.stream_last, res_ch.stream_last);
            mismatch_cnt++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

      // start_ip write, only requested while the block is idle
      if (ip_ch.valid && ip_ch.ready) begin
        ip_ch.valid <= 1'b0;
        ip_base = ip_ch.start_ip;
        cfg_req = 1'b0;
      end else if (cfg_req && !ip_ch.valid) begin
        ip_ch.valid    <= 1'b1;
        ip_ch.start_ip <= cfg_value;
      end

      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL x86_call_jump_branch_decoder");
      $finish;
    end
  end

  // wait until everything sent has come back, then let the pipeline settle
  task automatic wait_drained();
    while (raw_q.size() != 0 || decoded_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sequencer: changes shared state at the falling edge, apart from the reset release
  initial begin : sequencer
    logic [31:0] ip_plan [PHASES];
    int          fed;
    int          got;
    byte_ch.valid      = 1'b0;
    byte_ch.in_byte    = '0;
    byte_ch.stream_end = 1'b0;
    res_ch.ready       = 1'b0;
    ip_ch.valid        = 1'b0;
    ip_ch.start_ip     = '0;
    rst                = 1'b1;

    // start_ip plan: both extremes, a wrap case and random values
    ip_plan[0] = 32'hFFFF_FFFF;
    ip_plan[1] = 32'hFFFF_FFF9;
    ip_plan[2] = $urandom;
    ip_plan[3] = 32'h0000_0000;
    ip_plan[4] = $urandom;
    ip_plan[5] = 32'h7FFF_FFFF;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset value of start_ip
    send_idle_pct = 17;
    recv_idle_pct = 82;
    for (int i = 0; i < DIR_N; i++)
      raw_q.push_back(DIR_ROWS[i]);
    wait_drained();

    // random phases: receiver idles first, then the sender, then neither
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 2) ? 17 : (p < 4) ? 82 : 0;
      recv_idle_pct = (p < 2) ? 82 : (p < 4) ? 17 : 0;
      cfg_value = ip_plan[p];
      cfg_req   = 1'b1;
      while (cfg_req || ip_ch.valid)
        @(negedge clk);
      fed = 0;
      while (fed < PHASE_ITEMS) begin
        queue_stream(got);
        fed += got;
      end
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("PASS x86_call_jump_branch_decoder");
    end else begin
      $display("FAIL x86_call_jump_branch_decoder");
    end
    $finish;
  end

endmodule

FILE: x86_call_jump_branch_decoder.f
hw/rtl/xbd_pkg.sv
hw/rtl/xbd_ifs.sv
hw/rtl/xbd_window.sv
hw/rtl/xbd_fix.sv
hw/rtl/xbd_out_queue.sv
hw/rtl/x86_call_jump_branch_decoder.sv
dv/tb_x86_call_jump_branch_decoder.sv
